### hw/rtl/pfa_pkg.sv
// Package of shared constants, types and codes for the period frequency averager.
package pfa_pkg;

  // Tick rate of the free-running timestamp counter, in ticks per second.
  localparam int unsigned TICK_RATE = 1000000;

  // Field and register widths.
  localparam int STAMP_W = 64;
  localparam int FREQ_W = 32;
  localparam int SUM_W = 40;
  localparam int COUNT_W = 8;
  localparam int MIN_PERIOD_W = 20;
  localparam int MIN_FREQ_W = 16;
  localparam int WINDOW_W = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 2;

  // Numerator of the frequency division: TICK_RATE in Q16.16.
  localparam logic [63:0] FREQ_NUM = 64'(TICK_RATE) << 16;
  localparam int NUM_W = $clog2(FREQ_NUM + 64'd1);

  // The shared divider handles the frequency and the mean divisions.
  localparam int DIV_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_FREQ = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RESET = 20'd15000;
  localparam logic [MIN_FREQ_W-1:0] MIN_FREQ_RESET = 16'd50;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd200;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FDIV,
    S_ACC,
    S_TEST,
    S_ADIV,
    S_EMIT
  } pfa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_stamp;
    logic start_fdiv;
    logic start_adiv;
    logic cap_freq;
    logic acc;
    logic cap_avg;
    logic zero_avg;
    logic clear;
  } pfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic period_ok;
    logic freq_ok;
    logic win_full;
    logic count_zero;
    logic div_done;
  } pfa_status_t;

endpackage

### hw/rtl/pfa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pfa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfa_pkg::DIV_W-1:0]   dividend,
  input  logic [pfa_pkg::STAMP_W-1:0] divisor,
  output logic [pfa_pkg::DIV_W-1:0]   quotient,
  output logic                        done
);
  import pfa_pkg::*;

  logic                   busy;
  logic [DIV_CNT_W-1:0]   count;
  logic [DIV_W-1:0]       rem;
  logic [DIV_W-1:0]       dq;
  logic [STAMP_W-1:0]     dvs;

  logic [DIV_W:0]         shifted;
  logic [STAMP_W-1:0]     shifted_ext;
  logic                   ge;
  logic [STAMP_W-1:0]     diff;

  always_comb begin
    shifted = {rem, dq[DIV_W-1]};
    shifted_ext = {{(STAMP_W-DIV_W-1){1'b0}}, shifted};
    ge = shifted_ext >= dvs;
    diff = shifted_ext - dvs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The partial remainder never exceeds the dividend, so DIV_W bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      dq <= {dq[DIV_W-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule

### hw/rtl/pfa_datapath.sv
// Datapath: period, frequency, running sum, sample count and mean.
module pfa_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  pfa_pkg::pfa_cmd_t                cmd,
  input  logic [pfa_pkg::STAMP_W-1:0]      stamp,
  input  logic [pfa_pkg::MIN_PERIOD_W-1:0] min_period,
  input  logic [pfa_pkg::MIN_FREQ_W-1:0]   min_freq,
  input  logic [pfa_pkg::WINDOW_W-1:0]     window,
  output pfa_pkg::pfa_status_t             status,
  output logic [pfa_pkg::FREQ_W-1:0]       avg
);
  import pfa_pkg::*;

  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] period;
  logic [FREQ_W-1:0]  freq;
  logic [SUM_W-1:0]   freq_sum;
  logic [COUNT_W-1:0] sample_count;

  logic [DIV_W-1:0]   div_dividend;
  logic [STAMP_W-1:0] div_divisor;
  logic [DIV_W-1:0]   div_quotient;
  logic               div_done;

  always_comb begin
    if (cmd.start_adiv) begin
      div_dividend = DIV_W'(freq_sum);
      div_divisor = STAMP_W'(sample_count);
    end else begin
      div_dividend = DIV_W'(FREQ_NUM);
      div_divisor = period;
    end
  end

  pfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_fdiv | cmd.start_adiv),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp <= '0;
      freq_sum <= '0;
      sample_count <= '0;
    end else begin
      if (cmd.load_stamp) begin
        last_stamp <= stamp;
      end
      if (cmd.clear) begin
        freq_sum <= '0;
        sample_count <= '0;
      end else if (cmd.acc && status.freq_ok) begin
        freq_sum <= freq_sum + SUM_W'(freq);
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stamp) begin
      period <= stamp - last_stamp;
    end
    // Frequencies above the 32-bit range saturate.
    if (cmd.cap_freq) begin
      freq <= (|div_quotient[DIV_W-1:FREQ_W]) ? '1 : div_quotient[FREQ_W-1:0];
    end
    if (cmd.zero_avg) begin
      avg <= '0;
    end else if (cmd.cap_avg) begin
      avg <= div_quotient[FREQ_W-1:0];
    end
  end

  always_comb begin
    status.period_ok = period > STAMP_W'(min_period);
    status.freq_ok = freq > {min_freq, 16'd0};
    status.win_full = sample_count >= window;
    status.count_zero = sample_count == '0;
    status.div_done = div_done;
  end

endmodule

### hw/rtl/pfa_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module pfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_free,
  input  pfa_pkg::pfa_status_t status,
  output pfa_pkg::pfa_cmd_t    cmd,
  output logic                 emit
);
  import pfa_pkg::*;

  pfa_state_t state;
  pfa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.period_ok ? S_FDIV : S_IDLE;
      end
      S_FDIV: begin
        if (status.div_done) state_next = S_ACC;
      end
      S_ACC: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        if (!status.win_full) state_next = S_IDLE;
        else if (status.count_zero) state_next = S_EMIT;
        else state_next = S_ADIV;
      end
      S_ADIV: begin
        if (status.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    emit = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_stamp = in_valid;
      end
      S_CHECK: begin
        cmd.start_fdiv = status.period_ok;
      end
      S_FDIV: begin
        cmd.cap_freq = status.div_done;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
      end
      S_TEST: begin
        cmd.zero_avg = status.win_full && status.count_zero;
        cmd.start_adiv = status.win_full && !status.count_zero;
      end
      S_ADIV: begin
        cmd.cap_avg = status.div_done;
      end
      S_EMIT: begin
        emit = out_free;
        cmd.clear = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/period_frequency_averager.sv
// Top level of the period frequency averager: configuration, control, datapath, output register.
//
// Each input item is a 64-bit timestamp of a mains pulse edge from a free-running
// tick counter. The block takes the period since the previous timestamp (modulo
// 2^64, the first one measured from zero), drops periods not above min_period,
// turns the rest into a Q16.16 frequency TICK_RATE*65536/period (saturated to 32
// bits), sums frequencies above min_freq hertz, and after window samples emits
// the truncated mean as one result item and starts a new window. One shared
// restoring divider, one quotient bit per cycle on a 40-bit dividend, does both
// divisions: an invalid edge is dropped after the period check, a valid edge goes
// through the frequency division, and one that closes the window also through the
// mean division (skipped when no sample is held, which reports zero). The block
// takes one item at a time; a finished result waits for a free output register,
// then in it while the next item is taken. The user must write the configuration
// registers through cfg_we, cfg_index and cfg_data only while the block is idle,
// which the block does not enforce; an index beyond the three registers is ignored.
module period_frequency_averager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pfa_pkg::STAMP_W-1:0]       s_tdata,   // timestamp
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pfa_pkg::FREQ_W-1:0]        m_tdata,   // avg_frequency
  input  logic                              cfg_we,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pfa_pkg::*;

  logic [MIN_PERIOD_W-1:0] min_period;
  logic [MIN_FREQ_W-1:0]   min_freq;
  logic [WINDOW_W-1:0]     window;

  pfa_cmd_t    cmd;
  pfa_status_t status;
  logic        emit;
  logic        out_free;
  logic [FREQ_W-1:0] avg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period <= MIN_PERIOD_RESET;
      min_freq <= MIN_FREQ_RESET;
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_PERIOD: min_period <= cfg_data[MIN_PERIOD_W-1:0];
        REG_MIN_FREQ:   min_freq <= cfg_data[MIN_FREQ_W-1:0];
        REG_WINDOW:     window <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register is free when empty or being taken this cycle.
  assign out_free = !m_tvalid || m_tready;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .emit     (emit)
  );

  pfa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stamp      (s_tdata),
    .min_period (min_period),
    .min_freq   (min_freq),
    .window     (window),
    .status     (status),
    .avg        (avg)
  );

  // Output register holding a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= avg;
    end
  end

`ifndef SYNTHESIS
  // An accepted item keeps the input closed in the following cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A result is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending output item");

  // A loaded result is presented with the loaded value.
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid && (m_tdata == $past(avg)))
    else $error("emitted result not presented");
`endif

endmodule

### tb/sv/tb_period_frequency_averager.sv
// Self-checking testbench for the period frequency averager: directed and random items.
module tb_period_frequency_averager;
  import pfa_pkg::*;

  // Run limits. The watchdog limit leaves several times the slowest run, counting the
  // block's slowest item and the longest stalls of sender and receiver around each one.
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned CALM_TAIL = 250;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 1200000;
  localparam int unsigned MAX_REPORTS = 20;
  localparam int PLAN_ROWS = 33;

  // The configuration port has room for a fourth index that maps to no register.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ROW_EDGE,
    ROW_MIN_PERIOD,
    ROW_MIN_FREQ,
    ROW_WINDOW,
    ROW_UNMAPPED
  } plan_kind_t;

  // One row of the directed table. Edge rows carry an absolute timestamp; register
  // rows carry the value to write. A pinned row carries the average it must produce.
  typedef struct {
    plan_kind_t        kind;
    logic [63:0]       value;
    bit                pinned;
    logic [FREQ_W-1:0] avg;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [STAMP_W-1:0] s_tdata;     // timestamp
  logic m_tvalid;
  logic m_tready;
  logic [FREQ_W-1:0] m_tdata;      // avg_frequency
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Typed expectation that travels with the item on the bus, for pinned table rows.
  bit pin_row;
  logic [FREQ_W-1:0] pin_value;

  // Averages the block still owes, oldest first.
  logic [FREQ_W-1:0] pending_avgs [$];

  // Private copy of the averager: registers and running state.
  logic [MIN_PERIOD_W-1:0] min_period_cfg = MIN_PERIOD_RESET;
  logic [MIN_FREQ_W-1:0] min_freq_cfg = MIN_FREQ_RESET;
  logic [WINDOW_W-1:0] window_cfg = WINDOW_RESET;
  logic [STAMP_W-1:0] prev_stamp = '0;
  logic [COUNT_W-1:0] held = '0;
  logic [SUM_W-1:0] freq_sum = '0;

  // Stimulus and bookkeeping.
  bit calm = 1'b0;
  bit in_flight = 1'b0;
  logic [STAMP_W-1:0] stamp_gen = '0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned edges_taken = 0;
  int unsigned avgs_checked = 0;
  int unsigned settings = 0;
  plan_row_t plan [PLAN_ROWS];

  period_frequency_averager DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // One line per mismatch, capped so that a broken block cannot flood the log.
  task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] got,
                                 input logic [FREQ_W-1:0] want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("MISMATCH cycle %0d: %s: got %h, expected %h", cycles, what, got, want);
    end
  endtask

  // Advances the private averager by one timestamp. The period wraps modulo 2^64 and
  // the stamp is kept even when the edge is rejected. The frequency saturates at 32
  // bits before it is compared with min_freq or summed, and the count test is made
  // on every valid edge, so a full or over-full window closes even when the
  // frequency itself was rejected. A window of zero closes on every valid edge.
  task automatic predict_average(input logic [STAMP_W-1:0] stamp, output bit emitted,
                                 output logic [FREQ_W-1:0] avg);
    logic [63:0] period;
    logic [63:0] freq;
    logic [SUM_W-1:0] mean;
    emitted = 1'b0;
    avg = '0;
    period = stamp - prev_stamp;
    prev_stamp = stamp;
    if (period > 64'(min_period_cfg)) begin
      freq = FREQ_NUM / period;
      if (freq > 64'hFFFF_FFFF) begin
        freq = 64'hFFFF_FFFF;
      end
      if (freq > {32'd0, min_freq_cfg, 16'd0}) begin
        freq_sum = freq_sum + freq[SUM_W-1:0];
        held = held + 8'd1;
      end
      if (held >= window_cfg) begin
        mean = (held != 0) ? freq_sum / SUM_W'(held) : '0;
        avg = mean[FREQ_W-1:0];
        emitted = 1'b1;
        freq_sum = '0;
        held = '0;
      end
    end
  endtask

  // Every accepted timestamp runs through the private averager. A pinned row's typed
  // average takes the place of the computed one.
  always @(posedge clk) begin : predict_on_accept
    bit emitted;
    logic [FREQ_W-1:0] avg;
    if (!rst && s_tvalid && s_tready) begin
      predict_average(s_tdata, emitted, avg);
      edges_taken++;
      if (emitted || pin_row) begin
        pending_avgs.push_back(pin_row ? pin_value : avg);
      end
    end
  end

  // Every accepted result must match the oldest outstanding average.
  always @(posedge clk) begin : check_average
    logic [FREQ_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_avgs.size() == 0) begin
        report_mismatch("avg_frequency with nothing expected", m_tdata, '0);
      end else begin
        want = pending_avgs.pop_front();
        avgs_checked++;
        if (m_tdata !== want) begin
          report_mismatch("avg_frequency", m_tdata, want);
        end
      end
    end
  end

  // Receiver: ready runs of random length broken by stalls of random length,
  // and ready held high once the calm tail of the run begins.
  initial begin : result_sink
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if ($urandom_range(0, 1) == 1) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d averages outstanding.", cycles,
             pending_avgs.size());
    $display("tb_period_frequency_averager NOT OK");
    $finish;
  end

  // Offers one timestamp and returns at the edge that accepts it. Valid stays high
  // into the next call unless that call opens a gap first.
  task automatic send_edge(input logic [STAMP_W-1:0] stamp, input bit pinned,
                           input logic [FREQ_W-1:0] avg);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= stamp;
    pin_row <= pinned;
    pin_value <= avg;
    stamp_gen = stamp;
    in_flight = 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering items and waits for every owed average. If an item went in since
  // the last pause, the block may still be busy on an edge that makes no result, so
  // it is given its worst-case latency on top.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_avgs.size() != 0);
    if (in_flight) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    in_flight = 1'b0;
  endtask

  // One register write, with write enable taken low again after it. The private copy
  // keeps only the register's own width and ignores the unused index.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_PERIOD: min_period_cfg = data[MIN_PERIOD_W-1:0];
      REG_MIN_FREQ:   min_freq_cfg = data[MIN_FREQ_W-1:0];
      REG_WINDOW:     window_cfg = data[WINDOW_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned mp;
    int unsigned mf;
    int unsigned win;
    int unsigned center;
    int unsigned spread;
    logic [STAMP_W-1:0] stamp;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    pin_row <= 1'b0;
    pin_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MIN_PERIOD;
    cfg_data <= '0;

    // Directed table. Pinned averages follow directly from the arithmetic: 1e6 ticks
    // is 1 Hz, 20000 ticks is 50 Hz, 1000 ticks is 1000 Hz, a period of 15 ticks or
    // less saturates, and 1000001 ticks floors to 65535 in Q16.16.
    plan = '{
      // First period after reset is measured from zero; 10000 ticks is too short.
      '{ROW_EDGE,       64'd10000,             1'b0, 32'h0},
      '{ROW_MIN_FREQ,   64'd0,                 1'b0, 32'h0},
      '{ROW_WINDOW,     64'd1,                 1'b0, 32'h0},
      '{ROW_EDGE,       64'd1010000,           1'b1, 32'h0001_0000},
      '{ROW_EDGE,       64'd1030000,           1'b1, 32'h0032_0000},
      // A repeated stamp and a period exactly at min_period are both ignored.
      '{ROW_EDGE,       64'd1030000,           1'b0, 32'h0},
      '{ROW_EDGE,       64'd1045000,           1'b0, 32'h0},
      '{ROW_EDGE,       64'd1060001,           1'b0, 32'h0},
      // A huge period gives a zero frequency, which fails even a zero min_freq.
      '{ROW_EDGE,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      // The subtraction wraps: from all ones to 19999 is 20000 ticks.
      '{ROW_EDGE,       64'd19999,             1'b1, 32'h0032_0000},
      // Exactly 50 Hz does not exceed a 50 Hz floor; one tick less does.
      '{ROW_MIN_FREQ,   64'd50,                1'b0, 32'h0},
      '{ROW_EDGE,       64'd39999,             1'b0, 32'h0},
      '{ROW_EDGE,       64'd59998,             1'b0, 32'h0},
      // Saturation with no period floor and the highest frequency floor.
      '{ROW_MIN_PERIOD, 64'd0,                 1'b0, 32'h0},
      '{ROW_MIN_FREQ,   64'd65535,             1'b0, 32'h0},
      '{ROW_EDGE,       64'd59999,             1'b1, 32'hFFFF_FFFF},
      '{ROW_EDGE,       64'd60014,             1'b1, 32'hFFFF_FFFF},
      '{ROW_EDGE,       64'd60030,             1'b0, 32'h0},
      '{ROW_EDGE,       64'd60030,             1'b0, 32'h0},
      // A zero window reports on every valid edge, zero when nothing is held.
      '{ROW_WINDOW,     64'd0,                 1'b0, 32'h0},
      '{ROW_EDGE,       64'd60046,             1'b1, 32'h0},
      '{ROW_MIN_FREQ,   64'd0,                 1'b0, 32'h0},
      '{ROW_EDGE,       64'd61046,             1'b1, 32'h03E8_0000},
      // A period floor of 1000000 ticks and the largest window: gather two samples, then shrink the window.
      '{ROW_MIN_PERIOD, 64'd1000000,           1'b0, 32'h0},
      '{ROW_WINDOW,     64'd255,               1'b0, 32'h0},
      '{ROW_EDGE,       64'd1061047,           1'b0, 32'h0},
      '{ROW_EDGE,       64'd2061047,           1'b0, 32'h0},
      '{ROW_EDGE,       64'd4061047,           1'b0, 32'h0},
      '{ROW_WINDOW,     64'd1,                 1'b0, 32'h0},
      // A rejected frequency still closes the over-full window.
      '{ROW_EDGE,       (64'd1 << 40) + 64'd4061047, 1'b0, 32'h0},
      '{ROW_EDGE,       (64'd1 << 40) + 64'd5061048, 1'b1, 32'h0000_FFFF},
      // A write to the unused index must leave every register alone.
      '{ROW_UNMAPPED,   64'hFFFFF,             1'b0, 32'h0},
      '{ROW_EDGE,       (64'd1 << 40) + 64'd6061049, 1'b1, 32'h0000_FFFF}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind != ROW_EDGE) begin
        quiesce();
      end
      case (plan[r].kind)
        ROW_EDGE:       send_edge(plan[r].value, plan[r].pinned, plan[r].avg);
        ROW_MIN_PERIOD: write_reg(REG_MIN_PERIOD, plan[r].value[CFG_DATA_W-1:0]);
        ROW_MIN_FREQ:   write_reg(REG_MIN_FREQ, plan[r].value[CFG_DATA_W-1:0]);
        ROW_WINDOW:     write_reg(REG_WINDOW, plan[r].value[CFG_DATA_W-1:0]);
        default:        write_reg(REG_UNUSED, plan[r].value[CFG_DATA_W-1:0]);
      endcase
    end

    // Random phases. Each phase writes all three registers while the block is idle,
    // then sends mostly plausible edge sequences whose periods straddle min_period,
    // with min_freq placed near the resulting frequencies so that samples are both
    // kept and dropped. The rest is noise: tiny periods, huge periods and stamps
    // that jump anywhere in the 64-bit range.
    sent = 0;
    while (sent < ITEM_TARGET) begin
      quiesce();
      if (sent + CALM_TAIL >= ITEM_TARGET) begin
        calm = 1'b1;
      end

      case ($urandom_range(0, 7))
        0:       mp = 0;
        1:       mp = 15;
        2:       mp = MIN_PERIOD_RESET;
        3:       mp = 1000000;
        4:       mp = 20'hFFFFF;
        5:       mp = $urandom_range(16, 400);
        default: mp = $urandom_range(5000, 40000);
      endcase
      center = TICK_RATE / (mp + mp / 4 + 33);
      case ($urandom_range(0, 7))
        0:       mf = 0;
        1:       mf = 16'hFFFF;
        default: mf = $urandom_range(0, center + center / 2);
      endcase
      if (mf > 16'hFFFF) begin
        mf = 16'hFFFF;
      end
      case ($urandom_range(0, 9))
        0:       win = 0;
        1:       win = 255;
        2:       win = 1;
        default: win = $urandom_range(2, 12);
      endcase

      // Bits above a narrow register's width are set at random; they must be dropped.
      write_reg(REG_MIN_PERIOD, CFG_DATA_W'(mp));
      write_reg(REG_MIN_FREQ, {4'($urandom()), MIN_FREQ_W'(mf)});
      write_reg(REG_WINDOW, {12'($urandom()), WINDOW_W'(win)});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      end
      settings++;

      spread = mp / 2 + 64;
      phase_len = $urandom_range(40, 200);
      for (int k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          stamp = stamp_gen + 64'(mp) + 64'd1 + 64'($urandom_range(0, spread));
        end else if (pick < 76) begin
          stamp = stamp_gen + 64'(mp);
        end else if (pick < 80) begin
          stamp = stamp_gen + 64'(mp) + 64'd1;
        end else if (pick < 86) begin
          stamp = stamp_gen + 64'($urandom_range(0, 40));
        end else if (pick < 93) begin
          stamp = {$urandom(), $urandom()};
        end else begin
          stamp = stamp_gen + ({$urandom(), $urandom()} >> $urandom_range(0, 63));
        end
        send_edge(stamp, 1'b0, '0);
        sent++;
        // Now and then hold off until the block has delivered everything it owes.
        if (!calm && $urandom_range(0, 149) == 0) begin
          quiesce();
        end
      end
    end

    quiesce();

    $display("Covered %0d timestamp items and %0d averages over %0d random register settings",
             edges_taken, avgs_checked, settings);
    $display("plus the directed edge cases; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("tb_period_frequency_averager OK");
    end else begin
      $display("tb_period_frequency_averager NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_div.sv
hw/rtl/pfa_datapath.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/period_frequency_averager.sv
tb/sv/tb_period_frequency_averager.sv
